### hw/rtl/sha512_pkg.sv
// Package with beat types, round constants and SHA-512 helper functions.
package sha512_pkg;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;
  } out_beat_t;

  // Word handed from the front part to the core: a block word and a
  // flag that marks the final word of a message (the length word).
  typedef struct packed {
    logic [63:0] word;
    logic        msg_end;
  } wq_beat_t;

  typedef enum logic [1:0] {
    FrIdle,
    FrFill,
    FrLen
  } front_state_e;

  typedef enum logic [1:0] {
    CoLoad,
    CoRound,
    CoAdd,
    CoEmit
  } core_state_e;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw = $clog2(QDepth);

  localparam logic [63:0] InitHash [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
    64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [63:0] RoundK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic logic [63:0] ror64(input logic [63:0] v, input int unsigned s);
    return (v >> s) | (v << (64 - s));
  endfunction

  function automatic logic [63:0] sig0(input logic [63:0] x);
    return ror64(x, 1) ^ ror64(x, 8) ^ (x >> 7);
  endfunction

  function automatic logic [63:0] sig1(input logic [63:0] x);
    return ror64(x, 19) ^ ror64(x, 61) ^ (x >> 6);
  endfunction

  function automatic logic [63:0] bsig0(input logic [63:0] x);
    return ror64(x, 28) ^ ror64(x, 34) ^ ror64(x, 39);
  endfunction

  function automatic logic [63:0] bsig1(input logic [63:0] x);
    return ror64(x, 14) ^ ror64(x, 18) ^ ror64(x, 41);
  endfunction

endpackage

### hw/rtl/sha512_stream_hash_core.sv
// Streaming SHA-512: a padding front end, a word queue and a round core.
// Each 16-word block is loaded word by word, then run through 80 rounds and an add;
// the round core has a single shared round unit and takes no new words while it runs.
// A last beat adds padding words and at most one extra block, then 8 digest beats.
// Reset (rst_ni low, asynchronous) loads the initial hash and zero length.
module sha512_stream_hash_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sha512_pkg::in_beat_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sha512_pkg::out_beat_t out_data_o
);

  logic fq_valid, fq_ready, qc_valid, qc_ready;
  sha512_pkg::wq_beat_t fq_data, qc_data;

  sha512_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .wq_valid_o(fq_valid), .wq_ready_i(fq_ready), .wq_data_o(fq_data)
  );

  sha512_wqueue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fq_valid), .wr_ready_o(fq_ready), .wr_data_i(fq_data),
    .rd_valid_o(qc_valid), .rd_ready_i(qc_ready), .rd_data_o(qc_data)
  );

  sha512_core u_core (
    .clk_i, .rst_ni,
    .wq_valid_i(qc_valid), .wq_ready_o(qc_ready), .wq_data_i(qc_data),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule

### hw/rtl/sha512_front.sv
// Front part: takes message beats, applies padding and the length word.
module sha512_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sha512_pkg::in_beat_t in_data_i,
  output logic                 wq_valid_o,
  input  logic                 wq_ready_i,
  output sha512_pkg::wq_beat_t wq_data_o
);

  sha512_pkg::front_state_e state_q, state_d;
  logic [3:0]  pos_q, pos_d;
  logic [63:0] len_q, len_d;
  logic        pad8_q, pad8_d;

  logic [3:0]  cnt;
  logic [63:0] keep, pad, last_word;
  logic        push;

  // Clamp the byte count and build the padded final word.
  always_comb begin
    cnt = (in_data_i.byte_count > 4'd8) ? 4'd8 : in_data_i.byte_count;
    keep = (cnt == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> {cnt[3:0], 3'b000});
    pad = 64'h8000000000000000 >> {cnt[3:0], 3'b000};
    last_word = (cnt == 4'd8) ? in_data_i.data_word : ((in_data_i.data_word & keep) | pad);
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    pos_d = pos_q;
    len_d = len_q;
    pad8_d = pad8_q;
    push = wq_valid_o && wq_ready_i;
    case (state_q)
      sha512_pkg::FrIdle: begin
        if (push) begin
          pos_d = pos_q + 4'd1;
          if (in_data_i.last) begin
            len_d = len_q + {57'd0, cnt, 3'b000};
            pad8_d = (cnt == 4'd8);
            state_d = sha512_pkg::FrFill;
          end else begin
            len_d = len_q + 64'd64;
          end
        end
      end
      sha512_pkg::FrFill: begin
        if (push) begin
          pos_d = pos_q + 4'd1;
          pad8_d = 1'b0;
          if (pos_q == 4'd14 && !pad8_q) begin
            state_d = sha512_pkg::FrLen;
          end
        end
      end
      sha512_pkg::FrLen: begin
        if (push) begin
          pos_d = 4'd0;
          len_d = 64'd0;
          state_d = sha512_pkg::FrIdle;
        end
      end
      default: state_d = sha512_pkg::FrIdle;
    endcase
  end

  // Output logic.
  always_comb begin
    wq_valid_o = 1'b0;
    in_ready_o = 1'b0;
    wq_data_o.word = 64'd0;
    wq_data_o.msg_end = 1'b0;
    case (state_q)
      sha512_pkg::FrIdle: begin
        wq_valid_o = in_valid_i;
        in_ready_o = wq_ready_i;
        wq_data_o.word = in_data_i.last ? last_word : in_data_i.data_word;
      end
      sha512_pkg::FrFill: begin
        wq_valid_o = 1'b1;
        wq_data_o.word = pad8_q ? 64'h8000000000000000 : 64'd0;
      end
      sha512_pkg::FrLen: begin
        wq_valid_o = 1'b1;
        wq_data_o.word = len_q;
        wq_data_o.msg_end = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha512_pkg::FrIdle;
      pos_q <= 4'd0;
      len_q <= 64'd0;
      pad8_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q <= pos_d;
      len_q <= len_d;
      pad8_q <= pad8_d;
    end
  end

  // The length word always lands in the last slot of a block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sha512_pkg::FrLen |-> pos_q == 4'd15)
    else $error("length word not in last block slot");
  // Input is taken only while no padding is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == sha512_pkg::FrIdle)
    else $error("input taken during padding");
  // After the length word the position restarts at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha512_pkg::FrLen && push) |=> pos_q == 4'd0)
    else $error("position not cleared at message end");

endmodule

### hw/rtl/sha512_wqueue.sv
// Short FIFO of block words between the front part and the core.
module sha512_wqueue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_valid_i,
  output logic                 wr_ready_o,
  input  sha512_pkg::wq_beat_t wr_data_i,
  output logic                 rd_valid_o,
  input  logic                 rd_ready_i,
  output sha512_pkg::wq_beat_t rd_data_o
);

  sha512_pkg::wq_beat_t mem_q [sha512_pkg::QDepth];
  logic [sha512_pkg::QAw-1:0] wp_q, rp_q;
  logic [sha512_pkg::QAw:0]   cnt_q;
  logic wr, rd;

  assign wr_ready_o = cnt_q != (sha512_pkg::QAw+1)'(sha512_pkg::QDepth);
  assign rd_valid_o = cnt_q != '0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  // Storage is written at the write pointer only.
  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + sha512_pkg::QAw'(1);
      if (rd) rp_q <= rp_q + sha512_pkg::QAw'(1);
      cnt_q <= cnt_q + {{sha512_pkg::QAw{1'b0}}, wr} - {{sha512_pkg::QAw{1'b0}}, rd};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (sha512_pkg::QAw+1)'(sha512_pkg::QDepth))
    else $error("queue overfilled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr && !rd) |=> cnt_q == $past(cnt_q) + (sha512_pkg::QAw+1)'(1))
    else $error("fill count missed a write");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd && !wr) |=> cnt_q == $past(cnt_q) - (sha512_pkg::QAw+1)'(1))
    else $error("fill count missed a read");

endmodule

### hw/rtl/sha512_core.sv
// Back part: collects block words, runs 80 rounds, emits the digest.
module sha512_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wq_valid_i,
  output logic                  wq_ready_o,
  input  sha512_pkg::wq_beat_t  wq_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sha512_pkg::out_beat_t out_data_o
);

  sha512_pkg::core_state_e state_q, state_d;
  logic [63:0] h_q [8];
  logic [63:0] r_q [8];
  logic [63:0] w_q [16];
  logic [3:0]  pos_q;
  logic [6:0]  rnd_q;
  logic        end_q;
  logic [2:0]  oidx_q;

  logic take, fin, emit;
  logic [63:0] wt, t1, t2, wnew;

  assign take = wq_valid_i && wq_ready_o;
  assign emit = out_valid_o && out_ready_i;
  assign fin = (rnd_q == 7'd79);

  // Round datapath; w_q works as a 16-word sliding schedule window.
  always_comb begin
    wt = w_q[0];
    wnew = w_q[0] + sha512_pkg::sig0(w_q[1]) + w_q[9] + sha512_pkg::sig1(w_q[14]);
    t1 = r_q[7] + sha512_pkg::bsig1(r_q[4]) + ((r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6]))
       + sha512_pkg::RoundK[rnd_q] + wt;
    t2 = sha512_pkg::bsig0(r_q[0]) + ((r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]));
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sha512_pkg::CoLoad:  if (take && pos_q == 4'd15) state_d = sha512_pkg::CoRound;
      sha512_pkg::CoRound: if (fin) state_d = sha512_pkg::CoAdd;
      sha512_pkg::CoAdd:   state_d = end_q ? sha512_pkg::CoEmit : sha512_pkg::CoLoad;
      sha512_pkg::CoEmit:  if (emit && oidx_q == 3'd7) state_d = sha512_pkg::CoLoad;
      default:             state_d = sha512_pkg::CoLoad;
    endcase
  end

  // Output logic.
  always_comb begin
    wq_ready_o = (state_q == sha512_pkg::CoLoad);
    out_valid_o = (state_q == sha512_pkg::CoEmit);
    out_data_o.digest_word = h_q[oidx_q];
    out_data_o.word_index = oidx_q;
    out_data_o.digest_last = (oidx_q == 3'd7);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha512_pkg::CoLoad;
      pos_q <= 4'd0;
      rnd_q <= 7'd0;
      end_q <= 1'b0;
      oidx_q <= 3'd0;
      for (int i = 0; i < 8; i++) h_q[i] <= sha512_pkg::InitHash[i];
    end else begin
      state_q <= state_d;
      if (take) begin
        pos_q <= pos_q + 4'd1;
        end_q <= wq_data_i.msg_end;
      end
      if (state_q == sha512_pkg::CoRound) rnd_q <= fin ? 7'd0 : rnd_q + 7'd1;
      if (state_q == sha512_pkg::CoAdd) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + r_q[i];
      end
      if (emit) begin
        oidx_q <= oidx_q + 3'd1;
        if (oidx_q == 3'd7) begin
          for (int i = 0; i < 8; i++) h_q[i] <= sha512_pkg::InitHash[i];
        end
      end
    end
  end

  // Working variables and schedule window.
  always_ff @(posedge clk_i) begin
    if (take) begin
      w_q[pos_q] <= wq_data_i.word;
      if (pos_q == 4'd15) begin
        for (int i = 0; i < 8; i++) r_q[i] <= h_q[i];
      end
    end
    if (state_q == sha512_pkg::CoRound) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
      r_q[7] <= r_q[6];
      r_q[6] <= r_q[5];
      r_q[5] <= r_q[4];
      r_q[4] <= r_q[3] + t1;
      r_q[3] <= r_q[2];
      r_q[2] <= r_q[1];
      r_q[1] <= r_q[0];
      r_q[0] <= t1 + t2;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != sha512_pkg::CoRound |-> rnd_q == 7'd0)
    else $error("round counter moved outside rounds");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sha512_pkg::CoEmit |-> pos_q == 4'd0)
    else $error("digest out while block partly filled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha512_pkg::CoRound && fin) |=> state_q == sha512_pkg::CoAdd)
    else $error("rounds did not end in final add");

endmodule
